// ===== design/pts_pkg.sv =====
`default_nettype none
package pts_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [2:0] KIND_CONFIGURE = 3'd0;
  localparam logic [2:0] KIND_REMOVE    = 3'd1;
  localparam logic [2:0] KIND_PAUSE     = 3'd2;
  localparam logic [2:0] KIND_EXECUTE   = 3'd3;
  localparam logic [2:0] KIND_CONFIRM   = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_ENTRY  = 3'd1;
  localparam logic [2:0] ST_PAST      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_READY = 3'd4;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/pts_datapath.sv =====
`default_nettype none
module pts_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pts_pkg::ctl_cmd_t cmd,
  output pts_pkg::dp_stat_t      stat,
  input  wire logic [2:0]        in_kind,
  input  wire logic [63:0]       in_op_id,
  input  wire logic [63:0]       in_action_name,
  input  wire logic [63:0]       in_target_name,
  input  wire logic [31:0]       in_period_secs,
  input  wire logic [31:0]       in_start_secs,
  input  wire logic [7:0]        in_pause_value,
  input  wire logic [31:0]       in_now_secs,
  output logic [2:0]             out_status,
  output logic                   out_fired,
  output logic [63:0]            out_fired_id,
  output logic [63:0]            out_fired_action,
  output logic [63:0]            out_fired_target
);

  // request registers
  logic [2:0]  req_kind_r;
  logic [63:0] req_id_r;
  logic [63:0] req_action_r;
  logic [63:0] req_target_r;
  logic [31:0] req_period_r;
  logic [31:0] req_start_r;
  logic [7:0]  req_pause_r;
  logic [31:0] req_now_r;

  // slot table
  logic [pts_pkg::SLOTS-1:0] slot_valid_r;
  logic [63:0] slot_id_r     [pts_pkg::SLOTS];
  logic [63:0] slot_action_r [pts_pkg::SLOTS];
  logic [63:0] slot_target_r [pts_pkg::SLOTS];
  logic [31:0] slot_period_r [pts_pkg::SLOTS];
  logic [31:0] slot_last_r   [pts_pkg::SLOTS];
  logic        slot_paused_r [pts_pkg::SLOTS];

  // scan state
  logic [pts_pkg::SLOT_W-1:0] idx_r;
  logic                       found_r;
  logic [pts_pkg::SLOT_W-1:0] match_idx_r;
  logic                       free_found_r;
  logic [pts_pkg::SLOT_W-1:0] free_idx_r;
  logic                       best_found_r;
  logic [pts_pkg::SLOT_W-1:0] best_idx_r;
  logic [31:0]                best_last_r;
  logic [63:0]                best_id_r;

  // single read port, walks the table during the scan, then points at the winner
  logic [pts_pkg::SLOT_W-1:0] rd_idx;
  logic        rd_valid;
  logic [63:0] rd_id;
  logic [63:0] rd_action;
  logic [63:0] rd_target;
  logic [31:0] rd_period;
  logic [31:0] rd_last;
  logic        rd_paused;
  logic        rd_ready;
  logic        rd_better;

  assign rd_idx    = cmd.scan ? idx_r : best_idx_r;
  assign rd_valid  = slot_valid_r[rd_idx];
  assign rd_id     = slot_id_r[rd_idx];
  assign rd_action = slot_action_r[rd_idx];
  assign rd_target = slot_target_r[rd_idx];
  assign rd_period = slot_period_r[rd_idx];
  assign rd_last   = slot_last_r[rd_idx];
  assign rd_paused = slot_paused_r[rd_idx];

  assign rd_ready = rd_valid && !rd_paused && (rd_period != 32'd0) &&
                    ({1'b0, req_now_r} >= ({1'b0, rd_last} + {1'b0, rd_period}));
  assign rd_better = !best_found_r || (rd_last < best_last_r) ||
                     ((rd_last == best_last_r) && (rd_id < best_id_r));

  assign stat.scan_last = (idx_r == pts_pkg::SLOT_W'(pts_pkg::SLOTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind_r   <= in_kind;
      req_id_r     <= in_op_id;
      req_action_r <= in_action_name;
      req_target_r <= in_target_name;
      req_period_r <= in_period_secs;
      req_start_r  <= in_start_secs;
      req_pause_r  <= in_pause_value;
      req_now_r    <= in_now_secs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r        <= '0;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      if (rd_valid && (rd_id == req_id_r) && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= idx_r;
      end
      if (!rd_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (rd_ready && rd_better) begin
        best_found_r <= 1'b1;
        best_idx_r   <= idx_r;
        best_last_r  <= rd_last;
        best_id_r    <= rd_id;
      end
    end
  end

  // finish step: decide status and table writes
  logic                       we_new;
  logic                       we_upd;
  logic                       we_pause;
  logic                       we_last;
  logic                       clr_valid;
  logic [pts_pkg::SLOT_W-1:0] wr_idx;
  logic [31:0]                wr_last;
  logic [2:0]                 status;
  logic                       fired;
  logic [31:0]                base;
  logic [31:0]                new_last;

  assign base     = (req_start_r == 32'd0) ? req_now_r : req_start_r;
  assign new_last = (base >= req_period_r) ? (base - req_period_r) : 32'd0;

  always_comb begin
    we_new    = 1'b0;
    we_upd    = 1'b0;
    we_pause  = 1'b0;
    we_last   = 1'b0;
    clr_valid = 1'b0;
    wr_idx    = match_idx_r;
    wr_last   = req_now_r;
    status    = pts_pkg::ST_OK;
    fired     = 1'b0;
    case (req_kind_r)
      pts_pkg::KIND_CONFIGURE: begin
        if ((req_start_r != 32'd0) && (req_start_r < req_now_r)) begin
          status = pts_pkg::ST_PAST;
        end else if (found_r) begin
          we_upd = 1'b1;
        end else if (!free_found_r) begin
          status = pts_pkg::ST_FULL;
        end else begin
          we_new  = 1'b1;
          wr_idx  = free_idx_r;
          wr_last = new_last;
        end
      end
      pts_pkg::KIND_REMOVE: begin
        if (found_r) clr_valid = 1'b1;
        else status = pts_pkg::ST_NO_ENTRY;
      end
      pts_pkg::KIND_PAUSE: begin
        if (found_r) we_pause = 1'b1;
        else status = pts_pkg::ST_NO_ENTRY;
      end
      pts_pkg::KIND_EXECUTE: begin
        if (best_found_r) begin
          fired   = 1'b1;
          we_last = 1'b1;
          wr_idx  = best_idx_r;
        end else begin
          status = pts_pkg::ST_NOT_READY;
        end
      end
      pts_pkg::KIND_CONFIRM: begin
        if (found_r) we_last = 1'b1;
        else status = pts_pkg::ST_NO_ENTRY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.finish) begin
      if (we_new) slot_valid_r[wr_idx] <= 1'b1;
      else if (clr_valid) slot_valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (we_new) slot_id_r[wr_idx] <= req_id_r;
      if (we_new || we_upd) begin
        slot_action_r[wr_idx] <= req_action_r;
        slot_target_r[wr_idx] <= req_target_r;
        slot_period_r[wr_idx] <= req_period_r;
        slot_paused_r[wr_idx] <= 1'b0;
      end
      if (we_pause) slot_paused_r[wr_idx] <= (req_pause_r != 8'd0);
      if (we_new || we_last) slot_last_r[wr_idx] <= wr_last;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status       <= status;
      out_fired        <= fired;
      out_fired_id     <= fired ? rd_id : 64'd0;
      out_fired_action <= fired ? rd_action : 64'd0;
      out_fired_target <= fired ? rd_target : 64'd0;
    end
  end

endmodule
`default_nettype wire

// ===== design/pts_controller.sv =====
`default_nettype none
module pts_controller (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pts_pkg::ctl_cmd_t      cmd,
  input  wire pts_pkg::dp_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  assign cmd.load   = accept;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.finish = (state_r == S_DONE) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_SCAN;
      S_SCAN: if (stat.scan_last) state_nxt = S_DONE;
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // hold the result until taken, reload on finish
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN))
    else $error("accepted request did not start a scan");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan && stat.scan_last) |=> (state_r == S_DONE))
    else $error("scan did not end after the last slot");

  a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("finish did not present a result");

  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && !out_free) |=> (state_r == S_DONE))
    else $error("result step left while output was blocked");

endmodule
`default_nettype wire

// ===== design/periodic_task_scheduler.sv =====
// Periodic task scheduler: one request in flight at a time.
// After a request is accepted, every slot is scanned through the single table
// read port, then a decide/write step loads the result and raises out_valid.
// The next request is accepted once that result is loaded, later if out_stall holds.
// Reset (rst_n low, synchronous) clears all slot valid bits, the FSM and
// out_valid; slot payload stays undefined until written.
`default_nettype none
module periodic_task_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_kind,
  input  wire logic [63:0] in_op_id,
  input  wire logic [63:0] in_action_name,
  input  wire logic [63:0] in_target_name,
  input  wire logic [31:0] in_period_secs,
  input  wire logic [31:0] in_start_secs,
  input  wire logic [7:0]  in_pause_value,
  input  wire logic [31:0] in_now_secs,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic             out_fired,
  output logic [63:0]      out_fired_id,
  output logic [63:0]      out_fired_action,
  output logic [63:0]      out_fired_target
);

  pts_pkg::ctl_cmd_t cmd;
  pts_pkg::dp_stat_t stat;

  pts_controller u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  pts_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_kind),
    .in_op_id         (in_op_id),
    .in_action_name   (in_action_name),
    .in_target_name   (in_target_name),
    .in_period_secs   (in_period_secs),
    .in_start_secs    (in_start_secs),
    .in_pause_value   (in_pause_value),
    .in_now_secs      (in_now_secs),
    .out_status       (out_status),
    .out_fired        (out_fired),
    .out_fired_id     (out_fired_id),
    .out_fired_action (out_fired_action),
    .out_fired_target (out_fired_target)
  );

endmodule
`default_nettype wire
